@@ sv/tfer_pkg.sv @@
`default_nettype none

package tfer_pkg;

    // Default screen size in character cells
    localparam int DEF_WIDTH  = 128;
    localparam int DEF_HEIGHT = 64;

    // Field widths of the request and result
    localparam int COORD_W    = 12;
    localparam int GLYPH_W    = 8;
    localparam int ATTR_W     = 16;
    localparam int COUNT_W    = 14;
    localparam int RD_COL_W   = 7;
    localparam int RD_ROW_W   = 6;
    localparam int S_DATA_W   = 112;
    localparam int M_DATA_W   = 40;

    // Vertex difference, product and edge function widths
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int EDGE_W     = PROD_W + 1;

    // One stored cell: attribute above glyph
    localparam int CELL_W     = GLYPH_W + ATTR_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Request kinds carried on tuser
    localparam logic MODE_FILL = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Last setup step: writes back the last edge and loads the walk start
    localparam logic [1:0] SETUP_LAST = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       clear_en;
        logic       rd_en;
        logic       box_en;
        logic       setup_en;
        logic [1:0] setup_idx;
        logic       walk_en;
        logic       load_out;
    } tfer_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic box_empty;
        logic walk_last;
        logic out_free;
    } tfer_status_t;

endpackage

`default_nettype wire

@@ sv/triangle_fill_edge_raster.sv @@
// Triangle fill engine over a character-cell store of WIDTH x HEIGHT cells.
// Slave channel (s_): one request per transfer. tuser 0 fills a triangle
// given by three signed vertices with a glyph and attribute; tuser 1 reads
// one cell. Master channel (m_): exactly one result per request, carrying
// the read cell, or the number of cells written by a fill.
// Requests are handled one at a time. Steps from acceptance to m_tvalid:
//   read:                register the cell, then load the result
//   fill, box off screen: register the box, then load the result
//   fill:                 register the box, set up the edges, walk every cell of
//                         the clamped box, then load the result
// The box walk tests one cell per clock through the incremental edge unit and the single store write port.
// After reset a clearing sweep zeroes the store with s_tready low;
// requests are accepted once it ends.
// The result sits in an output register: the next request is accepted while
// it waits, and that request's result is held back until the receiver takes
// the earlier one, so a stalled m_tready never drops or repeats a result.
`default_nettype none

module triangle_fill_edge_raster
    import tfer_pkg::*;
#(
    parameter int WIDTH  = DEF_WIDTH,
    parameter int HEIGHT = DEF_HEIGHT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // mode
    input  wire logic                s_tuser,
    // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, glyph, attr,
    // read_col, read_row, zero fill
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // cell_glyph, cell_attr, cells_written, zero fill
    output logic [M_DATA_W-1:0]      m_tdata
);

    tfer_cmd_t    cmd;
    tfer_status_t status;

    tfer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tfer_datapath #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

@@ sv/tfer_ctrl.sv @@
`default_nettype none

module tfer_ctrl
    import tfer_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tuser,
    output logic              s_tready,
    input  wire tfer_status_t status,
    output tfer_cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_BOX    = 7'b0001000,
        ST_SETUP  = 7'b0010000,
        ST_WALK   = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;

    // Hold state and setup step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Sequence one request at a time
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd           = '0;
        cmd.setup_idx = step_reg;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (s_tuser == MODE_READ) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_BOX;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_BOX: begin
                cmd.box_en = 1'b1;
                step_next  = '0;
                if (status.box_empty) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup_en = 1'b1;
                step_next    = step_reg + 2'd1;
                if (step_reg == SETUP_LAST) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.walk_en = 1'b1;
                if (status.walk_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/tfer_datapath.sv @@
`default_nettype none

module tfer_datapath
    import tfer_pkg::*;
#(
    parameter int WIDTH  = DEF_WIDTH,
    parameter int HEIGHT = DEF_HEIGHT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tuser,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    input  wire tfer_cmd_t           cmd,
    output tfer_status_t             status
);

    localparam int CELLS  = WIDTH * HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT);

    localparam logic [ADDR_W-1:0]         WIDTH_A   = ADDR_W'(WIDTH);
    localparam logic [ADDR_W-1:0]         LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic signed [COORD_W-1:0] X_LIM     = COORD_W'(WIDTH - 1);
    localparam logic signed [COORD_W-1:0] Y_LIM     = COORD_W'(HEIGHT - 1);

    // Captured request
    logic                      mode_reg;
    logic signed [COORD_W-1:0] vx_reg [3];
    logic signed [COORD_W-1:0] vy_reg [3];
    logic [GLYPH_W-1:0]        glyph_reg;
    logic [ATTR_W-1:0]         attr_reg;
    logic [RD_COL_W-1:0]       rd_col_reg;
    logic [RD_ROW_W-1:0]       rd_row_reg;

    // Box, edge steps and walk state
    logic [COL_W-1:0]          x0_reg, x1_reg;
    logic [ROW_W-1:0]          y0_reg, y1_reg;
    logic signed [DIFF_W-1:0]  dx_reg [3];
    logic signed [DIFF_W-1:0]  dy_reg [3];
    logic signed [PROD_W-1:0]  p_reg, q_reg;
    logic signed [EDGE_W-1:0]  e_row_reg [3];
    logic signed [EDGE_W-1:0]  e_cur_reg [3];
    logic [COL_W-1:0]          col_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [ADDR_W-1:0]         row_base_reg;
    logic [COUNT_W-1:0]        count_reg;

    // Store, clearing sweep and read path
    logic [CELL_W-1:0]         cell_mem [CELLS];
    logic [ADDR_W-1:0]         clr_addr_reg;
    logic [CELL_W-1:0]         rdata_reg;
    logic                      in_range_reg;

    // Result register
    logic                      m_tvalid_reg;
    logic [M_DATA_W-1:0]       m_tdata_reg;

    // Combinational helpers
    logic signed [COORD_W-1:0] xmin, xmax, ymin, ymax;
    logic signed [COORD_W-1:0] x0c, x1c, y0c, y1c;
    logic signed [COORD_W-1:0] xa_s, ya_s;
    logic signed [DIFF_W-1:0]  dx_s, dy_s, ox, oy;
    logic signed [EDGE_W-1:0]  e_new;
    logic                      all_pos, all_neg, covered;
    logic                      col_end, row_end;
    logic [ADDR_W-1:0]         walk_addr, rd_addr;
    logic                      rd_in_range;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [CELL_W-1:0]         mem_wdata;
    logic [1:0]                wr_idx;

    // Capture the request fields
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= s_tuser;
            vx_reg[0]  <= s_tdata[11:0];
            vy_reg[0]  <= s_tdata[23:12];
            vx_reg[1]  <= s_tdata[35:24];
            vy_reg[1]  <= s_tdata[47:36];
            vx_reg[2]  <= s_tdata[59:48];
            vy_reg[2]  <= s_tdata[71:60];
            glyph_reg  <= s_tdata[79:72];
            attr_reg   <= s_tdata[95:80];
            rd_col_reg <= s_tdata[102:96];
            rd_row_reg <= s_tdata[108:103];
        end
    end

    // Bounding box of the vertices, clamped to the screen
    always_comb begin
        xmin = vx_reg[0];
        xmax = vx_reg[0];
        ymin = vy_reg[0];
        ymax = vy_reg[0];
        for (int k = 1; k < 3; k++) begin
            if (vx_reg[k] < xmin) xmin = vx_reg[k];
            if (vx_reg[k] > xmax) xmax = vx_reg[k];
            if (vy_reg[k] < ymin) ymin = vy_reg[k];
            if (vy_reg[k] > ymax) ymax = vy_reg[k];
        end
        x0c = (xmin < 0) ? '0 : xmin;
        y0c = (ymin < 0) ? '0 : ymin;
        x1c = (xmax > X_LIM) ? X_LIM : xmax;
        y1c = (ymax > Y_LIM) ? Y_LIM : ymax;
    end

    assign status.box_empty = (x0c > x1c) || (y0c > y1c);

    // Register the box and the per-edge steps
    always_ff @(posedge aclk) begin
        if (cmd.box_en) begin
            x0_reg    <= x0c[COL_W-1:0];
            x1_reg    <= x1c[COL_W-1:0];
            y0_reg    <= y0c[ROW_W-1:0];
            y1_reg    <= y1c[ROW_W-1:0];
            dx_reg[0] <= DIFF_W'(vx_reg[1]) - DIFF_W'(vx_reg[0]);
            dy_reg[0] <= DIFF_W'(vy_reg[1]) - DIFF_W'(vy_reg[0]);
            dx_reg[1] <= DIFF_W'(vx_reg[2]) - DIFF_W'(vx_reg[1]);
            dy_reg[1] <= DIFF_W'(vy_reg[2]) - DIFF_W'(vy_reg[1]);
            dx_reg[2] <= DIFF_W'(vx_reg[0]) - DIFF_W'(vx_reg[2]);
            dy_reg[2] <= DIFF_W'(vy_reg[0]) - DIFF_W'(vy_reg[2]);
        end
    end

    // Select the edge being set up
    always_comb begin
        case (cmd.setup_idx)
            2'd0: begin
                xa_s = vx_reg[0];
                ya_s = vy_reg[0];
                dx_s = dx_reg[0];
                dy_s = dy_reg[0];
            end
            2'd1: begin
                xa_s = vx_reg[1];
                ya_s = vy_reg[1];
                dx_s = dx_reg[1];
                dy_s = dy_reg[1];
            end
            default: begin
                xa_s = vx_reg[2];
                ya_s = vy_reg[2];
                dx_s = dx_reg[2];
                dy_s = dy_reg[2];
            end
        endcase
        ox     = $signed({{(DIFF_W - COL_W){1'b0}}, x0_reg}) - DIFF_W'(xa_s);
        oy     = $signed({{(DIFF_W - ROW_W){1'b0}}, y0_reg}) - DIFF_W'(ya_s);
        e_new  = EDGE_W'(p_reg) - EDGE_W'(q_reg);
        wr_idx = cmd.setup_idx - 2'd1;
    end

    // Cover test on the current cell, both windings
    always_comb begin
        all_pos = 1'b1;
        all_neg = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (e_cur_reg[k] < 0) all_pos = 1'b0;
            if (e_cur_reg[k] > 0) all_neg = 1'b0;
        end
        covered = all_pos || all_neg;
    end

    assign col_end          = (col_reg == x1_reg);
    assign row_end          = (row_reg == y1_reg);
    assign status.walk_last = col_end && row_end;
    assign walk_addr        = row_base_reg + ADDR_W'(col_reg);

    // Set up the edge functions at the box corner, then step them
    always_ff @(posedge aclk) begin
        if (cmd.setup_en) begin
            p_reg <= PROD_W'(ox) * PROD_W'(dy_s);
            q_reg <= PROD_W'(oy) * PROD_W'(dx_s);
            if (cmd.setup_idx != 2'd0) begin
                case (wr_idx)
                    2'd0: begin
                        e_row_reg[0] <= e_new;
                        e_cur_reg[0] <= e_new;
                    end
                    2'd1: begin
                        e_row_reg[1] <= e_new;
                        e_cur_reg[1] <= e_new;
                    end
                    default: begin
                        e_row_reg[2] <= e_new;
                        e_cur_reg[2] <= e_new;
                    end
                endcase
            end
            if (cmd.setup_idx == SETUP_LAST) begin
                col_reg      <= x0_reg;
                row_reg      <= y0_reg;
                row_base_reg <= ADDR_W'(ADDR_W'(y0_reg) * WIDTH_A);
            end
        end else if (cmd.walk_en) begin
            if (col_end) begin
                if (!row_end) begin
                    col_reg      <= x0_reg;
                    row_reg      <= row_reg + ROW_W'(1);
                    row_base_reg <= row_base_reg + WIDTH_A;
                    for (int k = 0; k < 3; k++) begin
                        e_row_reg[k] <= e_row_reg[k] - EDGE_W'(dx_reg[k]);
                        e_cur_reg[k] <= e_row_reg[k] - EDGE_W'(dx_reg[k]);
                    end
                end
            end else begin
                col_reg <= col_reg + COL_W'(1);
                for (int k = 0; k < 3; k++) begin
                    e_cur_reg[k] <= e_cur_reg[k] + EDGE_W'(dy_reg[k]);
                end
            end
        end
    end

    // Count written cells, saturating
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            count_reg <= '0;
        end else if (cmd.walk_en && covered && count_reg != COUNT_MAX) begin
            count_reg <= count_reg + COUNT_W'(1);
        end
    end

    // Advance the clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    assign status.clear_last = (clr_addr_reg == LAST_ADDR);

    // Store write port: clearing sweep or covered cell
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = walk_addr;
        mem_wdata = {attr_reg, glyph_reg};
        if (cmd.clear_en) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if (cmd.walk_en && covered) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Read port for a cell read request
    assign rd_in_range = (32'(rd_col_reg) < 32'(WIDTH)) && (32'(rd_row_reg) < 32'(HEIGHT));
    assign rd_addr     = ADDR_W'(32'(rd_row_reg) * 32'(WIDTH) + 32'(rd_col_reg));

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg    <= cell_mem[rd_addr];
            in_range_reg <= rd_in_range;
        end
    end

    // Result register, freed when the receiver takes it
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (mode_reg == MODE_READ) begin
                m_tdata_reg <= {2'b00, COUNT_W'(0), in_range_reg ? rdata_reg : CELL_W'(0)};
            end else begin
                m_tdata_reg <= {2'b00, count_reg, CELL_W'(0)};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ sv/tfer_checker.sv @@
`default_nettype none

module tfer_checker
    import tfer_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                s_tuser,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    logic s_fire;

    assign s_fire = s_tvalid && s_tready;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Take one request at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("request accepted while another is in progress");

    // Report either cell contents or a count, never both
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[37:24] == 14'd0) || (m_tdata[23:0] == 24'd0))
        else $error("result carries both cell data and a count");

    // Deliver a read on a free output straight through the read and result states
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_tuser == MODE_READ) && !m_tvalid |-> ##3 m_tvalid)
        else $error("read result late");

endmodule

bind triangle_fill_edge_raster tfer_checker u_tfer_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/triangle_fill_edge_raster_test.sv @@
`timescale 1ns / 1ps

module triangle_fill_edge_raster_test;
    import tfer_pkg::*;

    localparam int SCR_W       = DEF_WIDTH;
    localparam int SCR_H       = DEF_HEIGHT;
    localparam int TAIL_ITEMS  = 60;
    localparam int RANDOM_REQS = 560;
    localparam int LONG_HOLD   = 400;

    // One request on the slave channel
    typedef struct packed {
        logic                             mode;
        logic [2:0][COORD_W-1:0]          vx;
        logic [2:0][COORD_W-1:0]          vy;
        logic [GLYPH_W-1:0]               glyph;
        logic [ATTR_W-1:0]                attr;
        logic [RD_COL_W-1:0]              rd_col;
        logic [RD_ROW_W-1:0]              rd_row;
    } draw_req_t;

    localparam int REQ_W = $bits(draw_req_t);

    // One result on the master channel
    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [ATTR_W-1:0]  attr;
        logic [COUNT_W-1:0] count;
    } cell_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic                s_tuser  = MODE_FILL;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Screen image as the predictor sees it
    logic [GLYPH_W-1:0] glyph_image [SCR_W*SCR_H];
    logic [ATTR_W-1:0]  attr_image  [SCR_W*SCR_H];

    draw_req_t    request_queue [$];
    cell_result_t expected_cells [$];
    draw_req_t    offered_req;
    int           total_requests    = 0;
    int           requests_accepted = 0;
    int           results_taken     = 0;
    int           mismatches        = 0;
    int           send_gap          = 0;
    int           take_stall        = 0;
    int           hold_left         = 0;
    bit           hold_done         = 1'b0;
    bit           calm              = 1'b0;

    triangle_fill_edge_raster i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic longint edge_value(longint c, longint r, longint xa, longint ya,
                                          longint xb, longint yb);
        return c * (yb - ya) - r * (xb - xa) + (xb * ya - yb * xa);
    endfunction

    // Apply one request to the screen image and return its result
    function automatic cell_result_t render_request(draw_req_t rq);
        cell_result_t rs;
        longint       px [3];
        longint       py [3];
        longint       lo_x, hi_x, lo_y, hi_y, e0, e1, e2;
        int unsigned  hits;
        int           idx;
        rs   = '0;
        hits = 0;
        if (rq.mode == MODE_FILL) begin
            for (int k = 0; k < 3; k++) begin
                px[k] = $signed(rq.vx[k]);
                py[k] = $signed(rq.vy[k]);
            end
            lo_x = px[0]; hi_x = px[0]; lo_y = py[0]; hi_y = py[0];
            for (int k = 1; k < 3; k++) begin
                if (px[k] < lo_x) lo_x = px[k];
                if (px[k] > hi_x) hi_x = px[k];
                if (py[k] < lo_y) lo_y = py[k];
                if (py[k] > hi_y) hi_y = py[k];
            end
            // clamp the box to the screen
            if (lo_x < 0) lo_x = 0;
            if (lo_y < 0) lo_y = 0;
            if (hi_x > SCR_W - 1) hi_x = SCR_W - 1;
            if (hi_y > SCR_H - 1) hi_y = SCR_H - 1;
            for (longint r = lo_y; r <= hi_y; r++) begin
                for (longint c = lo_x; c <= hi_x; c++) begin
                    e0 = edge_value(c, r, px[0], py[0], px[1], py[1]);
                    e1 = edge_value(c, r, px[1], py[1], px[2], py[2]);
                    e2 = edge_value(c, r, px[2], py[2], px[0], py[0]);
                    if ((e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0)) begin
                        idx = int'(r) * SCR_W + int'(c);
                        glyph_image[idx] = rq.glyph;
                        attr_image[idx]  = rq.attr;
                        if (hits < COUNT_MAX) hits++;
                    end
                end
            end
            rs.count = COUNT_W'(hits);
        end else if (rq.rd_col < SCR_W && rq.rd_row < SCR_H) begin
            idx      = int'(rq.rd_row) * SCR_W + int'(rq.rd_col);
            rs.glyph = glyph_image[idx];
            rs.attr  = attr_image[idx];
        end
        return rs;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_request(draw_req_t rq);
        return S_DATA_W'({rq.rd_row, rq.rd_col, rq.attr, rq.glyph,
                          rq.vy[2], rq.vx[2], rq.vy[1], rq.vx[1], rq.vy[0], rq.vx[0]});
    endfunction

    // Queue a fill; the read fields carry noise
    task automatic queue_fill(int ax, int ay, int bx, int by, int cx, int cy, int g, int a);
        draw_req_t rq;
        rq.mode   = MODE_FILL;
        rq.vx[0]  = COORD_W'(ax);
        rq.vy[0]  = COORD_W'(ay);
        rq.vx[1]  = COORD_W'(bx);
        rq.vy[1]  = COORD_W'(by);
        rq.vx[2]  = COORD_W'(cx);
        rq.vy[2]  = COORD_W'(cy);
        rq.glyph  = GLYPH_W'(g);
        rq.attr   = ATTR_W'(a);
        rq.rd_col = RD_COL_W'($urandom);
        rq.rd_row = RD_ROW_W'($urandom);
        request_queue = {request_queue, rq};
    endtask

    // Queue a read; the fill fields carry noise
    task automatic queue_read(int col, int row);
        draw_req_t rq;
        rq        = REQ_W'({$urandom, $urandom, $urandom, $urandom});
        rq.mode   = MODE_READ;
        rq.rd_col = RD_COL_W'(col);
        rq.rd_row = RD_ROW_W'(row);
        request_queue = {request_queue, rq};
    endtask

    // Stimulus and end of run
    initial begin
        int pick, cx, cy, bx, by, qx, qy, rx, ry, last_x, last_y;
        last_x = 64;
        last_y = 32;

        // the store comes out of reset cleared
        foreach (glyph_image[i]) glyph_image[i] = '0;
        foreach (attr_image[i]) attr_image[i] = '0;

        // untouched store, corners
        queue_read(0, 0);
        queue_read(SCR_W - 1, SCR_H - 1);
        // huge triangle from the coordinate extremes, whole screen box
        queue_fill(-2048, -2048, 2047, 2047, -2048, 2047, 8'hFF, 16'hFFFF);
        queue_read(0, SCR_H - 1);
        queue_read(SCR_W - 1, 0);
        // both windings
        queue_fill(10, 5, 30, 5, 10, 20, 8'h41, 16'h1234);
        queue_fill(40, 5, 40, 20, 60, 5, 8'h42, 16'hABCD);
        // glyph zero written like any other
        queue_fill(20, 30, 35, 45, 5, 40, 0, 0);
        // boxes off screen: left, right, above, below
        queue_fill(-50, 10, -1, 20, -30, 40, 8'h11, 16'h1111);
        queue_fill(SCR_W, 0, 2047, 30, 500, 63, 8'h22, 16'h2222);
        queue_fill(10, -5, 50, -1, 30, -2048, 8'h33, 16'h3333);
        queue_fill(0, SCR_H, 100, 2047, 50, 70, 8'h44, 16'h4444);
        // degenerate: diagonal line, single point, horizontal line
        queue_fill(0, 0, 60, 30, 120, 60, 8'h2D, 16'h0F0F);
        queue_fill(64, 32, 64, 32, 64, 32, 8'h2A, 16'hF0F0);
        queue_fill(5, 50, 90, 50, 40, 50, 8'h3D, 16'h8001);
        queue_read(15, 8);
        queue_read(45, 8);
        queue_read(30, 40);
        queue_read(64, 32);
        queue_read(40, 50);
        queue_read(SCR_W - 1, SCR_H - 1);
        // opposite extremes on every vertex field
        queue_fill(2047, -2048, -2048, 2047, 2047, 2047, 8'hAA, 16'h5555);
        queue_read(0, 0);
        queue_read(SCR_W - 1, SCR_H - 1);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                queue_read($urandom_range(0, SCR_W - 1), $urandom_range(0, SCR_H - 1));
            end else if (pick < 36) begin
                // read near the latest fill
                rx = last_x + $urandom_range(0, 32) - 16;
                ry = last_y + $urandom_range(0, 32) - 16;
                if (rx < 0) rx = 0;
                if (rx > SCR_W - 1) rx = SCR_W - 1;
                if (ry < 0) ry = 0;
                if (ry > SCR_H - 1) ry = SCR_H - 1;
                queue_read(rx, ry);
            end else if (pick < 38) begin
                queue_fill($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                           $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                           $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                           $urandom, $urandom);
            end else if (pick < 43) begin
                // entirely right of or below the screen
                if ($urandom_range(0, 1) == 0)
                    queue_fill($urandom_range(SCR_W, 2047), $urandom_range(0, 4095) - 2048,
                               $urandom_range(SCR_W, 2047), $urandom_range(0, 4095) - 2048,
                               $urandom_range(SCR_W, 2047), $urandom_range(0, 4095) - 2048,
                               $urandom, $urandom);
                else
                    queue_fill($urandom_range(0, 4095) - 2048, $urandom_range(SCR_H, 2047),
                               $urandom_range(0, 4095) - 2048, $urandom_range(SCR_H, 2047),
                               $urandom_range(0, 4095) - 2048, $urandom_range(SCR_H, 2047),
                               $urandom, $urandom);
            end else begin
                // small triangle near the screen, sometimes degenerate
                cx = $urandom_range(0, SCR_W + 15) - 8;
                cy = $urandom_range(0, SCR_H + 15) - 8;
                bx = cx + $urandom_range(0, 32) - 16;
                by = cy + $urandom_range(0, 32) - 16;
                qx = cx + $urandom_range(0, 32) - 16;
                qy = cy + $urandom_range(0, 32) - 16;
                if ($urandom_range(0, 9) == 0) begin
                    qx = bx;
                    qy = by;
                end else if ($urandom_range(0, 9) == 0) begin
                    qx = 2 * bx - cx;
                    qy = 2 * by - cy;
                end
                queue_fill(cx, cy, bx, by, qx, qy, $urandom, $urandom);
                last_x = cx;
                last_y = cy;
            end
        end
        total_requests = request_queue.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // drain, then allow for a stray result
        while (requests_accepted != total_requests) @(posedge aclk);
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

    // Request driver: predict on acceptance, offer the next request with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_cells = {expected_cells, render_request(offered_req)};
                requests_accepted <= requests_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    offered_req = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= offered_req.mode;
                    s_tdata  <= pack_request(offered_req);
                    calm     <= (request_queue.size() < TAIL_ITEMS);
                    if (!calm && $urandom_range(0, 6) == 0) send_gap = $urandom_range(1, 12);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            take_stall = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && results_taken >= 120) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (take_stall > 0) begin
            take_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) take_stall = $urandom_range(1, 12);
        end
    end

    // Result monitor: compare against the oldest expected cell
    always @(posedge aclk) begin
        cell_result_t want;
        cell_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.glyph = m_tdata[7:0];
            got.attr  = m_tdata[23:8];
            got.count = m_tdata[37:24];
            results_taken <= results_taken + 1;
            if (expected_cells.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_cells.pop_front();
                if (got.glyph !== want.glyph) begin
                    $display("%0t: cell_glyph expected %0h actual %0h", $time, want.glyph,
                             got.glyph);
                    mismatches++;
                end
                if (got.attr !== want.attr) begin
                    $display("%0t: cell_attr expected %0h actual %0h", $time, want.attr,
                             got.attr);
                    mismatches++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: cells_written expected %0d actual %0d", $time, want.count,
                             got.count);
                    mismatches++;
                end
            end
        end
    end

endmodule
